// ===== rtl/core/icpr_pkg.sv =====
// Shared types and constants for the ICMP probe reply classifier.
package icpr_pkg;

	localparam int MAX_PACKET_BYTES = 65535;

	localparam int EXP_HOP_W  = 14;
	localparam int PROBE_ID_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_HOP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_ID     = 1'd1;

	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
	localparam logic [7:0] ICMP_TYPE_TIMEX = 8'd11;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_ECHO    = 2'd1,
		KIND_TIMEX   = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		VERDICT_ECHO_MATCH  = 3'd0,
		VERDICT_TIMEX_MATCH = 3'd1,
		VERDICT_MISMATCH    = 3'd2,
		VERDICT_OTHER_TYPE  = 3'd3,
		VERDICT_TRUNCATED   = 3'd4
	} verdict_t;

endpackage

// ===== rtl/core/icpr_if.sv =====
// Request channels of the classifier: packet bytes in, verdicts out.
interface icpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] pkt_byte;
	logic       last_byte;

	modport source (output valid, output pkt_byte, output last_byte, input ready);
	modport sink (input valid, input pkt_byte, input last_byte, output ready);
endinterface

interface icpr_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [31:0] responder_addr;
	logic [1:0]  probe_slot;

	modport source (output valid, output verdict, output responder_addr, output probe_slot,
		input ready);
	modport sink (input valid, input verdict, input responder_addr, input probe_slot,
		output ready);
endinterface

// ===== rtl/core/icmp_probe_reply_classifier_core.sv =====
// Classifies a received IPv4 packet, one byte per request, against the current ICMP probe.
//
// Each byte that is taken updates the per-packet offset, header length, reply
// kind, field positions and captured identifier and sequence through a single stage of
// offset compares. On the byte marked last, the verdict, responder address and probe slot
// are loaded into the output register at the edge that takes that byte and are offered from
// the next cycle; a new packet byte is accepted every cycle unless that register holds a
// result that the sink is not taking in that cycle. The sustained rate is one byte per
// cycle while the sink keeps taking results. Configuration writes are taken at any edge
// and must only be issued while no packet is in flight.
module icmp_probe_reply_classifier_core #(
	parameter int MAX_PACKET_BYTES = icpr_pkg::MAX_PACKET_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [icpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [icpr_pkg::CFG_DATA_W-1:0] cfg_data,
	icpr_byte_if.sink                        pkt,
	icpr_result_if.source                    res
);

	localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CMP_W = (OFF_W > 9) ? OFF_W : 9;

	logic [icpr_pkg::EXP_HOP_W-1:0]  expected_hop_q;
	logic [icpr_pkg::PROBE_ID_W-1:0] probe_id_q;

	logic [OFF_W-1:0]     byte_offset_q;
	logic [3:0]           hdr_words_q;
	icpr_pkg::kind_t      kind_q;
	logic [6:0]           inner_start_q;
	logic [7:0]           fields_start_q;
	logic [15:0]          seen_id_q;
	logic [15:0]          seen_seq_q;
	logic [31:0]          src_addr_q;
	logic                 fields_done_q;

	logic [OFF_W-1:0]     byte_offset_n;
	logic [3:0]           hdr_words_n;
	icpr_pkg::kind_t      kind_n;
	logic [6:0]           inner_start_n;
	logic [7:0]           fields_start_n;
	logic [15:0]          seen_id_n;
	logic [15:0]          seen_seq_n;
	logic [31:0]          src_addr_n;
	logic                 fields_done_n;

	logic                 accept;
	logic                 active;
	logic [CMP_W-1:0]     off_c;
	logic [CMP_W-1:0]     icmp_start_c;
	logic [CMP_W-1:0]     inner_c;
	logic [CMP_W-1:0]     fields_c;
	icpr_pkg::verdict_t   verdict_c;
	logic [1:0]           slot_c;

	logic                 res_valid_q;
	icpr_pkg::verdict_t   verdict_q;
	logic [31:0]          addr_q;
	logic [1:0]           slot_q;

	assign pkt.ready = !res_valid_q || res.ready;
	assign accept    = pkt.valid && pkt.ready;
	assign active    = byte_offset_q < OFF_W'(MAX_PACKET_BYTES);
	assign off_c     = CMP_W'(byte_offset_q);

	always_comb begin
		byte_offset_n  = byte_offset_q;
		hdr_words_n    = hdr_words_q;
		kind_n         = kind_q;
		inner_start_n  = inner_start_q;
		fields_start_n = fields_start_q;
		seen_id_n      = seen_id_q;
		seen_seq_n     = seen_seq_q;
		src_addr_n     = src_addr_q;
		fields_done_n  = fields_done_q;
		icmp_start_c   = '0;
		inner_c        = CMP_W'(inner_start_q);
		fields_c       = CMP_W'(fields_start_q);
		if (active) begin
			byte_offset_n = byte_offset_q + OFF_W'(1);
			if (off_c == '0) begin
				hdr_words_n = pkt.pkt_byte[3:0];
			end
			if (off_c >= CMP_W'(12) && off_c <= CMP_W'(15)) begin
				src_addr_n[8*(3 - int'(off_c[1:0])) +: 8] = pkt.pkt_byte;
			end
			// the header length of this very byte counts when it is byte 0
			icmp_start_c = CMP_W'({hdr_words_n, 2'b00});
			priority if (kind_q == icpr_pkg::KIND_UNKNOWN && off_c == icmp_start_c) begin
				fields_start_n = 8'({hdr_words_n, 2'b00});
				inner_start_n  = 7'({hdr_words_n, 2'b00}) + 7'd8;
				if (pkt.pkt_byte == icpr_pkg::ICMP_ECHO_REPLY) begin
					kind_n = icpr_pkg::KIND_ECHO;
				end else if (pkt.pkt_byte == icpr_pkg::ICMP_TYPE_TIMEX) begin
					kind_n = icpr_pkg::KIND_TIMEX;
				end else begin
					kind_n = icpr_pkg::KIND_OTHER;
				end
			end else if (kind_q == icpr_pkg::KIND_TIMEX && off_c == inner_c) begin
				fields_start_n = 8'(inner_start_q) + 8'({pkt.pkt_byte[3:0], 2'b00});
			end else if (kind_q == icpr_pkg::KIND_ECHO
					|| (kind_q == icpr_pkg::KIND_TIMEX && off_c > inner_c)) begin
				// identifier and sequence arrive low byte first
				if (off_c == fields_c + CMP_W'(4)) begin
					seen_id_n[7:0] = pkt.pkt_byte;
				end else if (off_c == fields_c + CMP_W'(5)) begin
					seen_id_n[15:8] = pkt.pkt_byte;
				end else if (off_c == fields_c + CMP_W'(6)) begin
					seen_seq_n[7:0] = pkt.pkt_byte;
				end else if (off_c == fields_c + CMP_W'(7)) begin
					seen_seq_n[15:8] = pkt.pkt_byte;
					fields_done_n    = 1'b1;
				end
			end else begin
				kind_n = kind_q;
			end
		end
	end

	always_comb begin
		slot_c = 2'd0;
		if (kind_n == icpr_pkg::KIND_UNKNOWN) begin
			verdict_c = icpr_pkg::VERDICT_TRUNCATED;
		end else if (kind_n == icpr_pkg::KIND_OTHER) begin
			verdict_c = icpr_pkg::VERDICT_OTHER_TYPE;
		end else if (!fields_done_n) begin
			verdict_c = icpr_pkg::VERDICT_TRUNCATED;
		end else begin
			slot_c = seen_seq_n[1:0];
			if (seen_seq_n[15:2] == expected_hop_q && seen_id_n == probe_id_q) begin
				verdict_c = (kind_n == icpr_pkg::KIND_ECHO) ? icpr_pkg::VERDICT_ECHO_MATCH
					: icpr_pkg::VERDICT_TIMEX_MATCH;
			end else begin
				verdict_c = icpr_pkg::VERDICT_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_hop_q <= icpr_pkg::EXP_HOP_W'(1);
			probe_id_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				icpr_pkg::REG_EXPECTED_HOP: expected_hop_q <= cfg_data[icpr_pkg::EXP_HOP_W-1:0];
				icpr_pkg::REG_PROBE_ID:     probe_id_q     <= cfg_data[icpr_pkg::PROBE_ID_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q  <= '0;
			hdr_words_q    <= '0;
			kind_q         <= icpr_pkg::KIND_UNKNOWN;
			inner_start_q  <= '0;
			fields_start_q <= '0;
			seen_id_q      <= '0;
			seen_seq_q     <= '0;
			src_addr_q     <= '0;
			fields_done_q  <= 1'b0;
		end else if (accept) begin
			if (pkt.last_byte) begin
				// drop all per-packet state as the verdict is loaded into the output register
				byte_offset_q  <= '0;
				hdr_words_q    <= '0;
				kind_q         <= icpr_pkg::KIND_UNKNOWN;
				inner_start_q  <= '0;
				fields_start_q <= '0;
				seen_id_q      <= '0;
				seen_seq_q     <= '0;
				src_addr_q     <= '0;
				fields_done_q  <= 1'b0;
			end else begin
				byte_offset_q  <= byte_offset_n;
				hdr_words_q    <= hdr_words_n;
				kind_q         <= kind_n;
				inner_start_q  <= inner_start_n;
				fields_start_q <= fields_start_n;
				seen_id_q      <= seen_id_n;
				seen_seq_q     <= seen_seq_n;
				src_addr_q     <= src_addr_n;
				fields_done_q  <= fields_done_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && pkt.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pkt.last_byte) begin
			verdict_q <= verdict_c;
			addr_q    <= src_addr_n;
			slot_q    <= slot_c;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.verdict        = verdict_q;
	assign res.responder_addr = addr_q;
	assign res.probe_slot     = slot_q;

`ifndef ASSERT_OFF
	a_offset_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		byte_offset_q <= OFF_W'(MAX_PACKET_BYTES))
		else $error("byte offset ran past the packet limit");

	a_fields_need_kind: assert property (@(posedge clk) disable iff (!arst_n)
		fields_done_q |-> (kind_q == icpr_pkg::KIND_ECHO || kind_q == icpr_pkg::KIND_TIMEX))
		else $error("fields captured without an echo or time exceeded type");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pkt.last_byte) |=> (res_valid_q && byte_offset_q == '0
			&& kind_q == icpr_pkg::KIND_UNKNOWN && !fields_done_q))
		else $error("last byte did not produce a result and clear the packet");

	a_slot_only_on_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (verdict_q == icpr_pkg::VERDICT_TRUNCATED
			|| verdict_q == icpr_pkg::VERDICT_OTHER_TYPE)) |-> slot_q == 2'd0)
		else $error("probe slot set without captured sequence");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the ICMP probe reply classifier core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import icpr_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	// Packet ceiling of the block under test: above the longest random reply built here
	localparam int TB_MAX_BYTES = 160;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] addr;
		logic [1:0]  slot;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	icpr_byte_if   pkt_if ();
	icpr_result_if res_if ();

	icmp_probe_reply_classifier_core #(
		.MAX_PACKET_BYTES (TB_MAX_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt       (pkt_if),
		.res       (res_if)
	);

	// Classifier state as the block should hold it
	logic [EXP_HOP_W-1:0]  cfg_hop;
	logic [PROBE_ID_W-1:0] cfg_id;
	int                    pkt_off;
	logic [3:0]            hdr_words;
	kind_t                 kind;
	int                    inner_pos;
	int                    fields_pos;
	logic [15:0]           id_seen;
	logic [15:0]           seq_seen;
	logic [31:0]           src_seen;
	logic                  fields_full;

	reply_t      expected_replies[$];
	logic [7:0]  frame[$];
	int          idle_pct;
	int          errors;
	int          items_sent;
	int          cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void clear_packet();
		pkt_off     = 0;
		hdr_words   = '0;
		kind        = KIND_UNKNOWN;
		inner_pos   = 0;
		fields_pos  = 0;
		id_seen     = '0;
		seq_seen    = '0;
		src_seen    = '0;
		fields_full = 1'b0;
	endfunction

	// Advance the classifier by one byte; emit is set on the last byte of a packet
	function automatic void absorb_byte(input logic [7:0] b, input logic last,
		output logic emit, output reply_t r);
		int icmp_pos;
		emit = 1'b0;
		r    = '0;
		if (pkt_off < TB_MAX_BYTES) begin
			if (pkt_off == 0)
				hdr_words = b[3:0];
			if (pkt_off >= 12 && pkt_off <= 15)
				src_seen[8*(15-pkt_off) +: 8] = b;
			icmp_pos = 4 * hdr_words;
			if (kind == KIND_UNKNOWN && pkt_off == icmp_pos) begin
				fields_pos = icmp_pos;
				inner_pos  = icmp_pos + 8;
				if (b == ICMP_ECHO_REPLY)
					kind = KIND_ECHO;
				else if (b == ICMP_TYPE_TIMEX)
					kind = KIND_TIMEX;
				else
					kind = KIND_OTHER;
			end else if (kind == KIND_TIMEX && pkt_off == inner_pos) begin
				fields_pos = inner_pos + 4 * b[3:0];
			end else if (kind == KIND_ECHO || (kind == KIND_TIMEX && pkt_off > inner_pos)) begin
				if (pkt_off == fields_pos + 4)
					id_seen[7:0] = b;
				else if (pkt_off == fields_pos + 5)
					id_seen[15:8] = b;
				else if (pkt_off == fields_pos + 6)
					seq_seen[7:0] = b;
				else if (pkt_off == fields_pos + 7) begin
					seq_seen[15:8] = b;
					fields_full    = 1'b1;
				end
			end
			pkt_off++;
		end
		if (last) begin
			emit   = 1'b1;
			r.addr = src_seen;
			r.slot = 2'd0;
			if (kind == KIND_UNKNOWN)
				r.verdict = VERDICT_TRUNCATED;
			else if (kind == KIND_OTHER)
				r.verdict = VERDICT_OTHER_TYPE;
			else if (!fields_full)
				r.verdict = VERDICT_TRUNCATED;
			else begin
				r.slot = seq_seen[1:0];
				if (seq_seen[15:2] == cfg_hop && id_seen == cfg_id)
					r.verdict = (kind == KIND_ECHO) ? VERDICT_ECHO_MATCH : VERDICT_TIMEX_MATCH;
				else
					r.verdict = VERDICT_MISMATCH;
			end
			clear_packet();
		end
	endfunction

	// Receiver: stall at random
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready = ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected reply, verdict %0d addr %h slot %0d", $time,
					res_if.verdict, res_if.responder_addr, res_if.probe_slot);
				errors++;
			end else begin
				want = expected_replies.pop_front();
				if (res_if.verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d, got %0d", $time, want.verdict,
						res_if.verdict);
					errors++;
				end
				if (res_if.responder_addr !== want.addr) begin
					$display("%0t: responder_addr expected %h, got %h", $time, want.addr,
						res_if.responder_addr);
					errors++;
				end
				if (res_if.probe_slot !== want.slot) begin
					$display("%0t: probe_slot expected %0d, got %0d", $time, want.slot,
						res_if.probe_slot);
					errors++;
				end
			end
		end
	end

	// Entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		logic   emit;
		reply_t r;
		while ($urandom_range(99) < idle_pct) begin
			pkt_if.valid = 1'b0;
			@(negedge clk);
		end
		pkt_if.valid     = 1'b1;
		pkt_if.pkt_byte  = b;
		pkt_if.last_byte = last;
		do @(posedge clk); while (pkt_if.ready !== 1'b1);
		absorb_byte(b, last, emit, r);
		if (emit)
			expected_replies.push_back(r);
		items_sent++;
		@(negedge clk);
		pkt_if.valid = 1'b0;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1);
	endtask

	task automatic wait_for_replies();
		pkt_if.valid = 1'b0;
		while (expected_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_EXPECTED_HOP)
			cfg_hop = data[EXP_HOP_W-1:0];
		else
			cfg_id = data;
	endtask

	task automatic set_config(input logic [15:0] hop_val, input logic [15:0] id_val);
		if ($urandom_range(1)) begin
			write_reg(REG_EXPECTED_HOP, hop_val);
			write_reg(REG_PROBE_ID, id_val);
		end else begin
			write_reg(REG_PROBE_ID, id_val);
			write_reg(REG_EXPECTED_HOP, hop_val);
		end
	endtask

	// Lay out a reply of the given type; identifier and sequence go low byte first
	task automatic make_reply(input logic [7:0] icmp_type, input int outer_ihl,
		input int inner_ihl, input logic [15:0] id_val, input logic [15:0] seq_val);
		int  icmp_pos;
		int  inner;
		int  fields;
		int  len;
		logic carries_fields;
		icmp_pos       = 4 * outer_ihl;
		inner          = icmp_pos + 8;
		carries_fields = (icmp_type == ICMP_ECHO_REPLY || icmp_type == ICMP_TYPE_TIMEX);
		fields         = (icmp_type == ICMP_TYPE_TIMEX) ? inner + 4 * inner_ihl : icmp_pos;
		len            = carries_fields ? fields + 8 : icmp_pos + 1 + $urandom_range(8);
		frame = {};
		for (int i = 0; i < len; i++)
			frame.push_back(8'($urandom_range(255)));
		frame[0]        = {frame[0][7:4], 4'(outer_ihl)};
		frame[icmp_pos] = icmp_type;
		if (icmp_type == ICMP_TYPE_TIMEX)
			frame[inner] = {frame[inner][7:4], 4'(inner_ihl)};
		if (carries_fields) begin
			frame[fields+4] = id_val[7:0];
			frame[fields+5] = id_val[15:8];
			frame[fields+6] = seq_val[7:0];
			frame[fields+7] = seq_val[15:8];
		end
	endtask

	task automatic send_random_reply();
		int          sel;
		int          cut;
		logic [7:0]  icmp_type;
		logic [15:0] id_val;
		logic [13:0] hop_val;
		sel = $urandom_range(99);
		if (sel < 10) begin
			// noise: bytes with no structure at all
			frame = {};
			repeat ($urandom_range(1, 40))
				frame.push_back(8'($urandom_range(255)));
		end else begin
			if (sel < 45)
				icmp_type = ICMP_ECHO_REPLY;
			else if (sel < 80)
				icmp_type = ICMP_TYPE_TIMEX;
			else begin
				do icmp_type = 8'($urandom_range(255));
				while (icmp_type == ICMP_ECHO_REPLY || icmp_type == ICMP_TYPE_TIMEX);
			end
			id_val  = ($urandom_range(99) < 75) ? cfg_id : 16'($urandom_range(65535));
			hop_val = ($urandom_range(99) < 75) ? cfg_hop : 14'($urandom_range(16383));
			make_reply(icmp_type,
				($urandom_range(99) < 70) ? 5 : $urandom_range(15),
				($urandom_range(99) < 70) ? 5 : $urandom_range(15),
				id_val, {hop_val, 2'($urandom_range(3))});
			if ($urandom_range(99) < 15 && frame.size() > 1) begin
				cut   = $urandom_range(1, frame.size() - 1);
				frame = frame[0:cut-1];
			end else begin
				repeat ($urandom_range(6))
					frame.push_back(8'($urandom_range(255)));
			end
		end
		send_frame();
	endtask

	// Reset values: hop 1, identifier 0
	task automatic test_defaults_after_reset();
		frame = {8'h00, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h07, 8'h00};
		send_frame();
		wait_for_replies();
	endtask

	task automatic test_short_and_other_type();
		frame = {8'hff};
		send_frame();
		frame = {8'h00, 8'h00};
		send_frame();
		frame = {8'h41, 8'h00, 8'h00, 8'h00, 8'hff};
		send_frame();
		wait_for_replies();
	endtask

	// Outer IHL 1, inner IHL 0, all ones in identifier and sequence
	task automatic test_time_exceeded_extremes();
		set_config(16'h3fff, 16'hffff);
		frame = {8'h01, 8'h00, 8'h00, 8'h00, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'hf0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
		send_frame();
		wait_for_replies();
	endtask

	task automatic test_random_phases();
		int          phase;
		int          first_item;
		int          packets;
		logic [15:0] hop_val;
		logic [15:0] id_val;
		phase      = 0;
		packets    = 0;
		first_item = items_sent;
		while (items_sent - first_item < 560 || packets < 16) begin
			case (phase)
				0: begin hop_val = 16'h0000; id_val = 16'h0000; end
				1: begin hop_val = 16'hffff; id_val = 16'hffff; end
				2: begin hop_val = 16'h0000; id_val = 16'hffff; end
				3: begin hop_val = 16'h3fff; id_val = 16'h0000; end
				default: begin
					hop_val = 16'($urandom_range(65535));
					id_val  = 16'($urandom_range(65535));
				end
			endcase
			// one phase runs flat out on both sides
			idle_pct = (phase == 2) ? 0 : 17;
			set_config(hop_val, id_val);
			repeat (4) begin
				send_random_reply();
				packets++;
			end
			wait_for_replies();
			phase++;
		end
		idle_pct = 17;
	endtask

	// Run well past the offset ceiling so that a counter that kept going would wrap
	task automatic test_overlong_packet();
		set_config(16'h0155, 16'ha5c3);
		make_reply(ICMP_ECHO_REPLY, 5, 5, cfg_id, {cfg_hop, 2'b10});
		while (frame.size() < TB_MAX_BYTES + 128)
			frame.push_back(8'($urandom_range(255)) | 8'h01);
		send_frame();
		wait_for_replies();
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pkt_if.valid     = 1'b0;
		pkt_if.pkt_byte  = '0;
		pkt_if.last_byte = 1'b0;
		idle_pct         = 17;
		errors           = 0;
		items_sent       = 0;
		cycles           = 0;
		cfg_hop          = 14'd1;
		cfg_id           = 16'd0;
		clear_packet();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_defaults_after_reset();
		test_short_and_other_type();
		test_time_exceeded_extremes();
		test_random_phases();
		test_overlong_packet();

		wait_for_replies();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
